FILE: hw/rtl/binary_mask_fmeasure_assert.svh
// assertion macros for the binary mask f-measure block
// used by binary_mask_fmeasure.sv, expects aclk and aresetn in scope
`ifndef BINARY_MASK_FMEASURE_ASSERT_SVH
`define BINARY_MASK_FMEASURE_ASSERT_SVH

// same-cycle implication
`define BMF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bmf assertion failed");

// next-cycle implication
`define BMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bmf assertion failed");

`endif

FILE: hw/rtl/bmf_pkg.sv
// shared constants, types and command/status structs of the f-measure block
// no dependencies
`default_nettype none

package bmf_pkg;

    localparam int COUNT_BITS   = 24;
    localparam int PIX_W        = 8;
    localparam int OUT_CNT_W    = 24;
    localparam int SCORE_W      = 15;
    localparam int SCALE2_W     = 16;
    localparam int NUM_W        = COUNT_BITS + SCALE2_W;
    localparam int DEN_W        = COUNT_BITS + 2;
    localparam int STEP_W       = $clog2(SCORE_W);

    localparam logic [SCALE2_W-1:0] SCALE2       = SCALE2_W'(51200);
    localparam logic [PIX_W-1:0]    THRESH_RESET = PIX_W'(100);
    localparam logic [STEP_W-1:0]   STEP_LAST    = STEP_W'(SCORE_W - 1);

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [OUT_CNT_W-1:0]  out_cnt_t;
    typedef logic [NUM_W-1:0]      num_t;
    typedef logic [DEN_W-1:0]      den_t;
    typedef logic [SCORE_W-1:0]    score_t;
    typedef logic [PIX_W-1:0]      pix_t;

    typedef struct packed {
        logic count_en;
        logic load;
        logic div_step;
        logic out_load;
    } bmf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } bmf_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bmf_ctrl.sv
// controller state machine: accumulate, load divider, divide, hand off result
// depends on bmf_pkg
`default_nettype none

module bmf_ctrl
    import bmf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_last_pixel,
    output logic          s_ready,
    input  wire bmf_sts_t sts,
    output bmf_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_ACCUM  = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_ACCUM);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_ACCUM: begin
                cmd.count_en = s_valid;
                if (s_valid && s_last_pixel) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.out_load = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bmf_dp.sv
// datapath: threshold register, saturating counters, scaled product,
// restoring divider and output register; depends on bmf_pkg
`default_nettype none

module bmf_dp
    import bmf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cfg_valid,
    input  wire pix_t     cfg_text_threshold,
    input  wire pix_t     s_truth_pixel,
    input  wire pix_t     s_test_pixel,
    input  wire bmf_cmd_t cmd,
    output bmf_sts_t      sts,
    input  wire logic     m_ready,
    output logic          m_valid,
    output score_t        m_score,
    output out_cnt_t      m_true_pos,
    output out_cnt_t      m_false_neg,
    output out_cnt_t      m_false_pos,
    output logic          m_no_match,
    output logic          m_saturated
);

    localparam count_t CNT_MAX = '1;

    pix_t        thr_reg;
    count_t      tp_reg, fn_reg, fp_reg;
    logic        sat_reg;
    den_t        den_reg, rem_reg;
    score_t      quo_reg;
    logic [STEP_W-1:0] step_reg;
    out_cnt_t    snap_tp_reg, snap_fn_reg, snap_fp_reg;
    logic        snap_nm_reg, snap_sat_reg;
    logic        m_valid_reg;
    score_t      m_score_reg;
    out_cnt_t    m_tp_reg, m_fn_reg, m_fp_reg;
    logic        m_nm_reg, m_sat_reg;

    logic        truth_text, test_text;
    logic        bump_tp, bump_fn, bump_fp;
    count_t      bump_cnt;
    logic        bump_sat;
    num_t        product;
    logic [DEN_W:0] trial;
    logic        ge;

    assign truth_text = (s_truth_pixel <= thr_reg);
    assign test_text  = (s_test_pixel <= thr_reg);
    assign bump_tp    = cmd.count_en && truth_text && test_text;
    assign bump_fn    = cmd.count_en && truth_text && !test_text;
    assign bump_fp    = cmd.count_en && !truth_text && test_text;

    // selected counter and whether it lands on its maximum
    always_comb begin
        priority if (bump_tp) begin
            bump_cnt = tp_reg;
        end else if (bump_fn) begin
            bump_cnt = fn_reg;
        end else begin
            bump_cnt = fp_reg;
        end
    end
    assign bump_sat = &bump_cnt[COUNT_BITS-1:1];

    assign product = num_t'(tp_reg) * num_t'(SCALE2);
    assign trial   = {rem_reg, quo_reg[SCORE_W-1]};
    assign ge      = (trial >= {1'b0, den_reg});

    assign sts.div_done = (step_reg == STEP_LAST);
    assign sts.out_free = !m_valid_reg || m_ready;

    // config register and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESH_RESET;
            tp_reg  <= '0;
            fn_reg  <= '0;
            fp_reg  <= '0;
            sat_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_text_threshold;
            end
            if (cmd.load) begin
                tp_reg  <= '0;
                fn_reg  <= '0;
                fp_reg  <= '0;
                sat_reg <= 1'b0;
            end else begin
                if (bump_tp && tp_reg != CNT_MAX) begin
                    tp_reg <= tp_reg + count_t'(1);
                end
                if (bump_fn && fn_reg != CNT_MAX) begin
                    fn_reg <= fn_reg + count_t'(1);
                end
                if (bump_fp && fp_reg != CNT_MAX) begin
                    fp_reg <= fp_reg + count_t'(1);
                end
                if ((bump_tp || bump_fn || bump_fp) && bump_sat) begin
                    sat_reg <= 1'b1;
                end
            end
        end
    end

    // divider: remainder starts at product >> SCORE_W since quotient < 2^SCORE_W
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.load) begin
            step_reg <= '0;
        end else if (cmd.div_step) begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            den_reg      <= den_t'({tp_reg, 1'b0}) + den_t'(fn_reg) + den_t'(fp_reg);
            rem_reg      <= den_t'(product[NUM_W-1:SCORE_W]);
            quo_reg      <= product[SCORE_W-1:0];
            snap_tp_reg  <= out_cnt_t'(tp_reg);
            snap_fn_reg  <= out_cnt_t'(fn_reg);
            snap_fp_reg  <= out_cnt_t'(fp_reg);
            snap_nm_reg  <= (tp_reg == '0);
            snap_sat_reg <= sat_reg;
        end else if (cmd.div_step) begin
            rem_reg <= ge ? den_t'(trial - {1'b0, den_reg}) : den_t'(trial);
            quo_reg <= {quo_reg[SCORE_W-2:0], ge};
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_score_reg <= snap_nm_reg ? '0 : quo_reg;
            m_tp_reg    <= snap_tp_reg;
            m_fn_reg    <= snap_fn_reg;
            m_fp_reg    <= snap_fp_reg;
            m_nm_reg    <= snap_nm_reg;
            m_sat_reg   <= snap_sat_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_score     = m_score_reg;
    assign m_true_pos  = m_tp_reg;
    assign m_false_neg = m_fn_reg;
    assign m_false_pos = m_fp_reg;
    assign m_no_match  = m_nm_reg;
    assign m_saturated = m_sat_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/binary_mask_fmeasure.sv
// top level of the binary mask f-measure block
// depends on bmf_pkg, bmf_ctrl, bmf_dp and binary_mask_fmeasure_assert.svh
//
//   channel   direction  payload
//   cfg       in         text_threshold (8b)
//   s         in         truth_pixel, test_pixel, last_pixel
//   m         out        score, true_pos, false_neg, false_pos, no_match, saturated
//
// one pixel item per cycle while accumulating
// a last item is followed by a load step and SCORE_W (15) restoring divider
// steps, then the result is handed to the output register once it is free
// s_ready stays low until the result register can take the new result
// synchronous active-low reset, threshold resets to 100, counters to zero
`default_nettype none

`include "binary_mask_fmeasure_assert.svh"

module binary_mask_fmeasure
    import bmf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire pix_t     cfg_text_threshold,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire pix_t     s_truth_pixel,
    input  wire pix_t     s_test_pixel,
    input  wire logic     s_last_pixel,
    output logic          m_valid,
    input  wire logic     m_ready,
    output score_t        m_score,
    output out_cnt_t      m_true_pos,
    output out_cnt_t      m_false_neg,
    output out_cnt_t      m_false_pos,
    output logic          m_no_match,
    output logic          m_saturated
);

    bmf_cmd_t cmd;
    bmf_sts_t sts;

    assign cfg_ready = 1'b1;

    bmf_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last_pixel (s_last_pixel),
        .s_ready      (s_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    bmf_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_text_threshold (cfg_text_threshold),
        .s_truth_pixel      (s_truth_pixel),
        .s_test_pixel       (s_test_pixel),
        .cmd                (cmd),
        .sts                (sts),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_score            (m_score),
        .m_true_pos         (m_true_pos),
        .m_false_neg        (m_false_neg),
        .m_false_pos        (m_false_pos),
        .m_no_match         (m_no_match),
        .m_saturated        (m_saturated)
    );

    `BMF_ASSERT_NEXT(a_busy_after_last, s_valid && s_ready && s_last_pixel, !s_ready && cmd.load)
    `BMF_ASSERT_NEXT(a_load_shows_result, cmd.out_load, m_valid)
    `BMF_ASSERT_NOW(a_no_match_zero, m_valid && m_no_match, m_score == '0)
    `BMF_ASSERT_NOW(a_load_when_free, cmd.out_load, !m_valid || m_ready)

endmodule

`default_nettype wire
